### rtl/core/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg: shared types, constants and helpers for the tournament predictor
// Holds the counter type, table defaults and the two-bit training function.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // two-bit saturating counter
  typedef logic [1:0] ctr_t;

  // default geometry
  localparam int unsigned GSHARE_ENTRIES_DEF  = 1024;
  localparam int unsigned BIMODAL_ENTRIES_DEF = 1024;
  localparam int unsigned CHOOSER_ENTRIES_DEF = 1024;
  localparam int unsigned HISTORY_BITS_DEF    = 10;

  // counter values
  localparam ctr_t CTR_MAX         = 2'd3;
  localparam ctr_t CTR_MIN         = 2'd0;
  localparam ctr_t CTR_TAKEN_MIN   = 2'd2;   // >= this predicts taken
  localparam ctr_t COMP_RST_VAL    = 2'd3;   // strongly taken
  localparam ctr_t CHOOSER_RST_VAL = 2'd1;   // weakly gshare

  // saturating totals
  localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

  // move a counter one step toward up/down, saturating at both ends
  function automatic ctr_t ctr_train(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

### rtl/core/tbp_ctr_table.sv
// ----------------------------------------------------------------------------
// tbp_ctr_table: table of two-bit counters in a synchronous memory
// One registered read port, one write port, and a clearing pass after reset
// that writes RST_VAL into every entry, one entry per cycle.
// ----------------------------------------------------------------------------
module tbp_ctr_table #(
  parameter int unsigned  ENTRIES = tbp_pkg::GSHARE_ENTRIES_DEF,
  parameter tbp_pkg::ctr_t RST_VAL = tbp_pkg::COMP_RST_VAL,
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output tbp_pkg::ctr_t        rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  tbp_pkg::ctr_t        wr_data,
  output logic                 clr_done
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  tbp_pkg::ctr_t     mem [ENTRIES];
  tbp_pkg::ctr_t     rd_data_r;
  logic [IDX_W-1:0]  clr_idx_r;
  logic              clr_busy_r;

  // clearing pass sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // write port: clear pass has priority (no items accepted meanwhile)
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= RST_VAL;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_done = !clr_busy_r;

endmodule

### rtl/core/tournament_branch_predictor_top.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor_top: gshare / bimodal tournament predictor
// Timing: table read on the input transfer edge, then update and result
//   register in ST_UPDATE, which out_tvalid follows; ST_UPDATE waits while
//   a previous result waits on out_tready.
// Flow: one branch at a time, set by the read-then-write-back of the
//   counter memories (read on the transfer, update in ST_UPDATE).
// Reset: synchronous rst_n; afterwards a clearing pass writes every entry of
//   the counter memories, in_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_top #(
  parameter int unsigned GSHARE_ENTRIES  = tbp_pkg::GSHARE_ENTRIES_DEF,
  parameter int unsigned BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF,
  parameter int unsigned CHOOSER_ENTRIES = tbp_pkg::CHOOSER_ENTRIES_DEF,
  parameter int unsigned HISTORY_BITS    = tbp_pkg::HISTORY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] branch_address, [32] actual_taken, [39:33] zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [0] predicted_taken, [1] used_gshare, [2] gshare_taken,
                                  // [3] bimodal_taken, [4] prediction_correct,
                                  // [36:5] branch_total, [68:37] correct_total, [71:69] zero
);

  localparam int unsigned G_IDX_W = (GSHARE_ENTRIES > 1)  ? $clog2(GSHARE_ENTRIES)  : 1;
  localparam int unsigned B_IDX_W = (BIMODAL_ENTRIES > 1) ? $clog2(BIMODAL_ENTRIES) : 1;
  localparam int unsigned C_IDX_W = (CHOOSER_ENTRIES > 1) ? $clog2(CHOOSER_ENTRIES) : 1;

  localparam logic [31:0] G_MASK = 32'(GSHARE_ENTRIES - 1);
  localparam logic [31:0] B_MASK = 32'(BIMODAL_ENTRIES - 1);
  localparam logic [31:0] C_MASK = 32'(CHOOSER_ENTRIES - 1);

  // sequencer states
  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic                    state_r, state_nxt;
  logic [HISTORY_BITS-1:0] hist_r, hist_nxt;
  logic [31:0]             branch_cnt_r, branch_cnt_nxt;
  logic [31:0]             correct_cnt_r, correct_cnt_nxt;
  logic [G_IDX_W-1:0]      g_idx_r;
  logic [B_IDX_W-1:0]      b_idx_r;
  logic [C_IDX_W-1:0]      c_idx_r;
  logic                    taken_r;
  logic                    out_valid_r;
  logic [71:0]             out_data_r;

  logic [31:0]             addr;
  logic [31:0]             g_idx_full;
  logic [G_IDX_W-1:0]      g_idx;
  logic [B_IDX_W-1:0]      b_idx;
  logic [C_IDX_W-1:0]      c_idx;
  logic                    in_xfer;
  logic                    upd_go;
  logic                    g_done, b_done, c_done;
  tbp_pkg::ctr_t           g_ctr, b_ctr, c_ctr;
  tbp_pkg::ctr_t           g_ctr_upd, b_ctr_upd, c_ctr_upd;
  logic                    g_pred, b_pred, use_g, pred, right;
  logic                    c_wr_en;

  // table indices from the incoming branch
  assign addr       = in_tdata[31:0];
  assign g_idx_full = (addr ^ 32'(hist_r)) & G_MASK;
  assign g_idx      = g_idx_full[G_IDX_W-1:0];
  assign b_idx      = B_IDX_W'(addr & B_MASK);
  assign c_idx      = C_IDX_W'(addr & C_MASK);

  // handshake: take a branch when idle and all tables are initialized
  assign in_tready = (state_r == ST_IDLE) && g_done && b_done && c_done;
  assign in_xfer   = in_tvalid && in_tready;
  assign upd_go    = (state_r == ST_UPDATE) && (!out_valid_r || out_tready);

  // counter memories
  tbp_ctr_table #(
    .ENTRIES (GSHARE_ENTRIES),
    .RST_VAL (tbp_pkg::COMP_RST_VAL)
  ) u_gshare (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_idx   (g_idx),
    .rd_data  (g_ctr),
    .wr_en    (upd_go),
    .wr_idx   (g_idx_r),
    .wr_data  (g_ctr_upd),
    .clr_done (g_done)
  );

  tbp_ctr_table #(
    .ENTRIES (BIMODAL_ENTRIES),
    .RST_VAL (tbp_pkg::COMP_RST_VAL)
  ) u_bimodal (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_idx   (b_idx),
    .rd_data  (b_ctr),
    .wr_en    (upd_go),
    .wr_idx   (b_idx_r),
    .wr_data  (b_ctr_upd),
    .clr_done (b_done)
  );

  tbp_ctr_table #(
    .ENTRIES (CHOOSER_ENTRIES),
    .RST_VAL (tbp_pkg::CHOOSER_RST_VAL)
  ) u_chooser (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_xfer),
    .rd_idx   (c_idx),
    .rd_data  (c_ctr),
    .wr_en    (c_wr_en),
    .wr_idx   (c_idx_r),
    .wr_data  (c_ctr_upd),
    .clr_done (c_done)
  );

  // prediction and training from the read counters
  always_comb begin
    g_pred    = (g_ctr >= tbp_pkg::CTR_TAKEN_MIN);
    b_pred    = (b_ctr >= tbp_pkg::CTR_TAKEN_MIN);
    use_g     = (c_ctr <  tbp_pkg::CTR_TAKEN_MIN);
    pred      = use_g ? g_pred : b_pred;
    right     = (pred == taken_r);
    g_ctr_upd = tbp_pkg::ctr_train(g_ctr, taken_r);
    b_ctr_upd = tbp_pkg::ctr_train(b_ctr, taken_r);
    // chooser moves toward bimodal when gshare missed
    c_ctr_upd = tbp_pkg::ctr_train(c_ctr, g_pred != taken_r);
    c_wr_en   = upd_go && (g_pred != b_pred);
  end

  // history and saturating totals
  always_comb begin
    hist_nxt        = hist_r;
    branch_cnt_nxt  = branch_cnt_r;
    correct_cnt_nxt = correct_cnt_r;
    if (upd_go) begin
      hist_nxt = HISTORY_BITS'({hist_r, taken_r});
      if (branch_cnt_r != tbp_pkg::COUNT_MAX) begin
        branch_cnt_nxt = branch_cnt_r + 32'd1;
      end
      if (right && (correct_cnt_r != tbp_pkg::COUNT_MAX)) begin
        correct_cnt_nxt = correct_cnt_r + 32'd1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      hist_r        <= '0;
      branch_cnt_r  <= '0;
      correct_cnt_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      hist_r        <= hist_nxt;
      branch_cnt_r  <= branch_cnt_nxt;
      correct_cnt_r <= correct_cnt_nxt;
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // captured item for write-back
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      g_idx_r <= g_idx;
      b_idx_r <= b_idx;
      c_idx_r <= c_idx;
      taken_r <= in_tdata[32];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_data_r <= {3'b000, correct_cnt_nxt, branch_cnt_nxt,
                     right, b_pred, g_pred, use_g, pred};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
